// ===== design/sha1md_pkg.sv =====
// Shared constants and round helpers for the SHA-1 message digest block.
// Depends on nothing; imported by sha1_message_digest.
package sha1md_pkg;

	localparam int WordW   = 32;
	localparam int NumHash = 5;
	localparam int NumSched = 16;
	localparam int NumRounds = 80;
	localparam int BlockBytes = 64;
	localparam int LenStart = 56;
	localparam int LenBytes = 8;

	localparam logic [7:0] PadByte = 8'h80;

	localparam logic [WordW-1:0] HashInit [NumHash] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [WordW-1:0] RoundK0 = 32'h5A827999;
	localparam logic [WordW-1:0] RoundK1 = 32'h6ED9EBA1;
	localparam logic [WordW-1:0] RoundK2 = 32'h8F1BBCDC;
	localparam logic [WordW-1:0] RoundK3 = 32'hCA62C1D6;

	// Boolean function of the round group, plus its additive constant
	function automatic logic [WordW-1:0] round_fk(
		input logic [6:0]       rnd,
		input logic [WordW-1:0] b,
		input logic [WordW-1:0] c,
		input logic [WordW-1:0] d
	);
		logic [WordW-1:0] f;
		logic [WordW-1:0] k;
		if (rnd < 7'd20) begin
			f = (b & c) | (~b & d);
			k = RoundK0;
		end else if (rnd < 7'd40) begin
			f = b ^ c ^ d;
			k = RoundK1;
		end else if (rnd < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
			k = RoundK2;
		end else begin
			f = b ^ c ^ d;
			k = RoundK3;
		end
		return f + k;
	endfunction

endpackage

// ===== design/sha1_message_digest.sv =====
// Streaming SHA-1 hasher: byte packing, padding sequencer, one round per cycle.
// Depends on sha1md_pkg for constants and the round function.
// Each accepted byte is packed into the block buffer; the 64th byte of a block starts a
// compression (80 rounds through the single round unit, then one chaining add).
// Finish: 9 to 72 padding bytes with one or two compressions, then
// five digest words, one per cycle when not stalled. Busy (stall high) meanwhile.
// Reset: asynchronous, restores the initial chaining words and an empty message.
module sha1_message_digest
	import sha1md_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [7:0]        message_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WordW-1:0]  digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_ADD,
		ST_OUT
	} state_t;

	localparam logic [5:0] FillLast   = 6'(BlockBytes - 1);
	localparam logic [5:0] FillLen    = 6'(LenStart);
	localparam logic [6:0] RoundLast  = 7'(NumRounds - 1);
	localparam logic [3:0] LenDone    = 4'(LenBytes);
	localparam logic [2:0] IdxLast    = 3'(NumHash - 1);

	state_t            state_q;
	logic [6:0]        round_q;
	logic [5:0]        fill_q;
	logic [60:0]       count_q;
	logic [2:0]        idx_q;
	logic              fin_q;
	logic              sent80_q;
	logic [3:0]        len_cnt_q;
	logic [WordW-1:0]  h_q [NumHash];
	logic              out_valid_q;

	logic [WordW-1:0]  w_q [NumSched];
	logic [WordW-1:0]  v_q [NumHash];
	logic [63:0]       len_q;

	logic              in_acc;
	logic              put_en;
	logic [7:0]        put_byte;
	logic              use_len;
	logic [WordW-1:0]  w_next;
	logic [WordW-1:0]  t_sum;

	assign in_acc = in_valid && !in_stall;

	// Byte source: message byte when idle, padding or length byte when padding
	always_comb begin
		put_en   = 1'b0;
		put_byte = message_byte;
		use_len  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				put_en = in_acc && !mode;
			end
			ST_PAD: begin
				put_en = 1'b1;
				if (!sent80_q) begin
					put_byte = PadByte;
				end else if (len_cnt_q == 4'd0 && fill_q != FillLen) begin
					put_byte = 8'h00;
				end else begin
					put_byte = len_q[63:56];
					use_len  = 1'b1;
				end
			end
			default: begin
				put_en = 1'b0;
			end
		endcase
	end

	// Round unit: message expansion and the five-operand add
	assign w_next = {w_q[13][WordW-2:0] ^ w_q[8][WordW-2:0] ^ w_q[2][WordW-2:0]
	                 ^ w_q[0][WordW-2:0],
	                 w_q[13][WordW-1] ^ w_q[8][WordW-1] ^ w_q[2][WordW-1] ^ w_q[0][WordW-1]};
	assign t_sum  = {v_q[0][26:0], v_q[0][31:27]} + v_q[4] + w_q[0]
	              + round_fk(round_q, v_q[1], v_q[2], v_q[3]);

	// Sequencer state, chaining words and registered output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			fill_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			fin_q       <= 1'b0;
			sent80_q    <= 1'b0;
			len_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NumHash; i++) begin
				h_q[i] <= HashInit[i];
			end
		end else begin
			if (state_q == ST_IDLE && in_acc && mode) begin
				fin_q   <= 1'b1;
				state_q <= ST_PAD;
			end
			if (state_q == ST_IDLE && put_en) begin
				count_q <= count_q + 61'd1;
			end
			if (state_q == ST_PAD) begin
				sent80_q <= 1'b1;
				if (use_len) begin
					len_cnt_q <= len_cnt_q + 4'd1;
				end
			end
			// Byte placement; a full buffer starts a compression
			if (put_en) begin
				if (fill_q == FillLast) begin
					fill_q  <= '0;
					round_q <= '0;
					state_q <= ST_COMP;
				end else begin
					fill_q <= fill_q + 6'd1;
				end
			end
			case (state_q)
				ST_COMP: begin
					if (round_q == RoundLast) begin
						round_q <= '0;
						state_q <= ST_ADD;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < NumHash; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (len_cnt_q == LenDone) begin
						state_q     <= ST_OUT;
						out_valid_q <= 1'b1;
						idx_q       <= '0;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						if (idx_q == IdxLast) begin
							for (int i = 0; i < NumHash; i++) begin
								h_q[i] <= HashInit[i];
							end
							idx_q       <= '0;
							count_q     <= '0;
							fill_q      <= '0;
							fin_q       <= 1'b0;
							sent80_q    <= 1'b0;
							len_cnt_q   <= '0;
							out_valid_q <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							for (int i = 0; i < NumHash - 1; i++) begin
								h_q[i] <= h_q[i + 1];
							end
							h_q[NumHash - 1] <= h_q[0];
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Block buffer (shifts bytes in, then rotates as the schedule), working words
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && mode) begin
			len_q <= {count_q, 3'b000};
		end else if (use_len) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (put_en) begin
			for (int i = 0; i < NumSched - 1; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
			end
			w_q[NumSched - 1] <= {w_q[NumSched - 1][23:0], put_byte};
			if (fill_q == FillLast) begin
				for (int i = 0; i < NumHash; i++) begin
					v_q[i] <= h_q[i];
				end
			end
		end else if (state_q == ST_COMP) begin
			for (int i = 0; i < NumSched - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[NumSched - 1] <= w_next;
			v_q[4] <= v_q[3];
			v_q[3] <= v_q[2];
			v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
			v_q[1] <= v_q[0];
			v_q[0] <= t_sum;
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign digest_word = h_q[0];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == IdxLast);

	// Checks on the sequencer
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("digest output while input side is open");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> (round_q <= RoundLast))
		else $error("round counter past last round");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_word) |=> (!out_valid && !in_stall))
		else $error("digest did not end after last word");

	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode) |=> (in_stall && !out_valid))
		else $error("finish request did not start padding");

endmodule

// ===== tb/sv/sha1md_tb_pkg.sv =====
// Request codes shared by the SHA-1 digest testbench files.
// Depends on nothing; imported by the checker and the testbench top.
package sha1md_tb_pkg;

	typedef enum logic {
		ModeAbsorb = 1'b0,
		ModeFinish = 1'b1
	} req_mode_e;

endpackage

// ===== tb/sv/sha1_digest_checker.sv =====
// Checker for sha1_message_digest: mirrors the hash state from accepted requests,
// queues the five expected digest words per finish, and compares each result.
// Depends on sha1md_pkg (constants) and sha1md_tb_pkg (request codes).
module sha1_digest_checker
	import sha1md_pkg::*;
	import sha1md_tb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              mode,
	input  logic [7:0]        message_byte,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [WordW-1:0]  digest_word,
	input  logic [2:0]        word_index,
	input  logic              last_word,
	output int                fail_cnt,
	output int                pending_cnt
);

	typedef struct packed {
		logic [WordW-1:0] word;
		logic [2:0]       idx;
		logic             last;
	} digest_word_t;

	// Mirrored hash state
	logic [WordW-1:0] chain_h [NumHash];
	logic [WordW-1:0] block_w [NumSched];
	logic [63:0]      msg_len;
	logic [5:0]       fill_pos;

	digest_word_t digest_q [$];
	digest_word_t got_word;
	digest_word_t want_word;
	int           fail_total;

	function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int n);
		return (v << n) | (v >> (WordW - n));
	endfunction

	task automatic clear_hash();
		for (int k = 0; k < NumHash; k++)
			chain_h[k] = HashInit[k];
		for (int k = 0; k < NumSched; k++)
			block_w[k] = '0;
		msg_len  = '0;
		fill_pos = '0;
	endtask

	// 80 rounds over the buffered block, then add into the chaining words
	task automatic compress_block();
		logic [WordW-1:0] w [NumSched];
		logic [WordW-1:0] a, b, c, d, e, f, kc, t, x;
		for (int k = 0; k < NumSched; k++)
			w[k] = block_w[k];
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < NumRounds; r++) begin
			if (r >= 16) begin
				x = w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16];
				w[r % 16] = rotl(x, 1);
			end
			if (r < 20) begin
				f  = (b & c) | (~b & d);
				kc = RoundK0;
			end else if (r < 40) begin
				f  = b ^ c ^ d;
				kc = RoundK1;
			end else if (r < 60) begin
				f  = (b & c) | (b & d) | (c & d);
				kc = RoundK2;
			end else begin
				f  = b ^ c ^ d;
				kc = RoundK3;
			end
			t = rotl(a, 5) + f + e + w[r % 16] + kc;
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] = chain_h[0] + a;
		chain_h[1] = chain_h[1] + b;
		chain_h[2] = chain_h[2] + c;
		chain_h[3] = chain_h[3] + d;
		chain_h[4] = chain_h[4] + e;
	endtask

	// Big-endian byte packing; a full block triggers compression
	task automatic absorb_byte(input logic [7:0] val);
		int               idx;
		int               sh;
		logic [WordW-1:0] w;
		idx = fill_pos[5:2];
		sh  = (3 - fill_pos[1:0]) * 8;
		w   = (fill_pos[1:0] == 2'd0) ? '0 : block_w[idx];
		w   = w & ~(32'hFF << sh);
		w   = w | ({24'b0, val} << sh);
		block_w[idx] = w;
		if (fill_pos == 6'(BlockBytes - 1)) begin
			compress_block();
			fill_pos = '0;
		end else begin
			fill_pos = fill_pos + 6'd1;
		end
	endtask

	// Padding, length field, digest words, back to the initial state
	task automatic finish_message();
		logic [63:0]  bit_len;
		digest_word_t dw;
		bit_len = msg_len << 3;
		absorb_byte(PadByte);
		while (fill_pos != 6'(LenStart))
			absorb_byte(8'h00);
		for (int k = 0; k < LenBytes; k++)
			absorb_byte(bit_len[63 - 8 * k -: 8]);
		for (int k = 0; k < NumHash; k++) begin
			dw.word = chain_h[k];
			dw.idx  = 3'(k);
			dw.last = (k == NumHash - 1);
			digest_q.push_back(dw);
		end
		clear_hash();
	endtask

	// Compare accepted results, then fold in the accepted request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_hash();
			digest_q.delete();
			fail_total = 0;
			fail_cnt    <= 0;
			pending_cnt <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got_word.word = digest_word;
				got_word.idx  = word_index;
				got_word.last = last_word;
				if (digest_q.size() == 0) begin
					if (fail_total < 10)
						$display("unexpected digest word %08h idx %0d last %0b",
							got_word.word, got_word.idx, got_word.last);
					fail_total++;
				end else begin
					want_word = digest_q.pop_front();
					if (got_word != want_word) begin
						if (fail_total < 10)
							$display("digest mismatch: got %08h/%0d/%0b, wanted %08h/%0d/%0b",
								got_word.word, got_word.idx, got_word.last,
								want_word.word, want_word.idx, want_word.last);
						fail_total++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (mode == ModeFinish) begin
					finish_message();
				end else begin
					absorb_byte(message_byte);
					msg_len = msg_len + 64'd1;
				end
			end
			fail_cnt    <= fail_total;
			pending_cnt <= digest_q.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the SHA-1 digest testbench: clock, reset, request stimulus and stall control.
// Depends on sha1_message_digest, sha1_digest_checker, sha1md_pkg and sha1md_tb_pkg.
module testbench;
	import sha1md_pkg::*;
	import sha1md_tb_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int TailCycles = 300;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             mode;
	logic [7:0]       message_byte;
	logic             out_valid;
	logic             out_stall;
	logic [WordW-1:0] digest_word;
	logic [2:0]       word_index;
	logic             last_word;
	int               fail_cnt;
	int               pending_cnt;

	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int          items_sent;
	int          cycle_cnt;

	sha1_message_digest i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.message_byte (message_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	sha1_digest_checker i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.message_byte (message_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word),
		.fail_cnt     (fail_cnt),
		.pending_cnt  (pending_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CycleLimit) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver stalls
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic set_phase(input int p);
		case (p)
			0: begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			1: begin
				send_idle_pct = 47;
				stall_pct     = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct     = 47;
			end
			default: begin
				send_idle_pct = 30;
				stall_pct     = 30;
			end
		endcase
	endtask

	// One request: optional idle cycles with junk payload, then hold until accepted
	task automatic send_request(input req_mode_e m, input logic [7:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid     <= 1'b0;
			mode         <= 1'($urandom);
			message_byte <= 8'($urandom);
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		message_byte <= val;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	task automatic send_message(input int len);
		for (int k = 0; k < len; k++)
			send_request(ModeAbsorb, 8'($urandom_range(255)));
		send_request(ModeFinish, 8'($urandom_range(255)));
	endtask

	initial begin
		int msg_no;
		int len;
		in_valid     = 1'b0;
		mode         = 1'b0;
		message_byte = 8'h00;
		items_sent   = 0;
		set_phase(0);
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty message, finish byte ignored, "abc", byte extremes
		send_request(ModeFinish, 8'h00);
		send_request(ModeFinish, 8'hFF);
		send_request(ModeAbsorb, 8'h61);
		send_request(ModeAbsorb, 8'h62);
		send_request(ModeAbsorb, 8'h63);
		send_request(ModeFinish, 8'h00);
		send_request(ModeAbsorb, 8'h00);
		send_request(ModeAbsorb, 8'hFF);
		send_request(ModeAbsorb, 8'h80);
		send_request(ModeAbsorb, 8'h7F);
		send_request(ModeAbsorb, 8'h01);
		send_request(ModeFinish, 8'hAA);

		// Random messages: mostly short, some around the padding boundaries
		msg_no = 0;
		while (items_sent < 210 || msg_no < 12) begin
			set_phase(msg_no % 4);
			if ($urandom_range(9) < 8) begin
				len = $urandom_range(8);
			end else begin
				case ($urandom_range(5))
					0: len = 55;
					1: len = 56;
					2: len = 57;
					3: len = 63;
					4: len = 64;
					default: len = 65;
				endcase
			end
			send_message(len);
			msg_no++;
		end

		// Drain
		@(negedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
